// File: sv/cwc_pkg.sv
// Package for the camera window capture block: types, register indexes and constants.
// Used by every module of the block; depends on nothing.

package cwc_pkg;

  localparam int CHUNK_PAYLOAD   = 240;
  localparam int MAX_LINE_PIXELS = 640;
  localparam int MAX_FRAME_LINES = 480;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // frame length is at most 11 by 9 bits wide
  localparam int LEN_W       = 20;
  localparam int CHUNK_SHIFT = LEN_W + $clog2(CHUNK_PAYLOAD);
  localparam int RECIP_W     = LEN_W + 1;
  localparam int PROD_W      = LEN_W + RECIP_W;
  localparam logic [63:0] CHUNK_RECIP =
    ((64'd1 << CHUNK_SHIFT) + 64'(CHUNK_PAYLOAD) - 64'd1) / 64'(CHUNK_PAYLOAD);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PIXELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LINES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_SKIP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_SKIP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE   = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_VSYNC,
    PH_ROWS,
    PH_LINE,
    PH_COLS,
    PH_GRAB
  } phase_t;

  typedef struct packed {
    logic       action;
    logic       vsync_pin;
    logic       href_pin;
    logic       pclk_pin;
    logic [7:0] data_pins;
  } in_t;

  typedef struct packed {
    logic [7:0]  pixel_byte;
    logic [19:0] byte_index;
    logic        line_end;
    logic        frame_end;
    logic [19:0] frame_bytes;
    logic [11:0] chunk_total;
  } out_t;

  typedef struct packed {
    logic [9:0] line_pixels;
    logic [8:0] frame_lines;
    logic [9:0] column_skip;
    logic [9:0] row_skip;
    logic       mono_mode;
  } cfg_t;

  // classified transaction handed from front to back
  typedef struct packed {
    logic       arm;
    logic       vs_rise;
    logic       hr_rise;
    logic       pc_rise;
    logic [7:0] data;
  } evt_t;

endpackage

// File: sv/cwc_front.sv
// Front end: takes pin samples and arm commands and turns them into edge events.
// Uses cwc_pkg; feeds cwc_queue.

module cwc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cwc_pkg::in_t   in_data,
  input  logic           q_full,
  output logic           q_push,
  output cwc_pkg::evt_t  q_data
);

  logic last_vsync_r, last_href_r, last_pclk_r;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.arm     = in_data.action;
    q_data.vs_rise = !last_vsync_r && in_data.vsync_pin;
    q_data.hr_rise = !last_href_r && in_data.href_pin;
    q_data.pc_rise = !last_pclk_r && in_data.pclk_pin;
    q_data.data    = in_data.data_pins;
  end

  // arm transactions leave the pin history alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_vsync_r <= 1'b0;
      last_href_r  <= 1'b0;
      last_pclk_r  <= 1'b0;
    end else if (q_push && !in_data.action) begin
      last_vsync_r <= in_data.vsync_pin;
      last_href_r  <= in_data.href_pin;
      last_pclk_r  <= in_data.pclk_pin;
    end
  end

endmodule

// File: sv/cwc_queue.sv
// Short register queue between the front and back of the capture block.
// Uses cwc_pkg for the event type and depth.

module cwc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cwc_pkg::evt_t  push_data,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output cwc_pkg::evt_t  q_data
);

  cwc_pkg::evt_t                    mem_r [cwc_pkg::QUEUE_DEPTH];
  logic [cwc_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [cwc_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [cwc_pkg::QCNT_W-1:0]       count_r, count_nxt;

  assign full    = (count_r == cwc_pkg::QCNT_W'(cwc_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == cwc_pkg::QPTR_W'(cwc_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == cwc_pkg::QPTR_W'(cwc_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/cwc_back.sv
// Back end: capture sequencer over edge events, frame length multiply and chunk count.
// Uses cwc_pkg; takes events from cwc_queue and drives the result channel.

module cwc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cwc_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  cwc_pkg::evt_t  q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output cwc_pkg::out_t  out_data
);

  cwc_pkg::phase_t phase_r, phase_nxt;
  logic            parity_r, parity_nxt;
  logic [9:0]      row_r, row_nxt;
  logic [11:0]     col_r, col_nxt;
  logic [19:0]     index_r, index_nxt;

  logic            s1_valid_r, s1_valid_nxt;
  cwc_pkg::out_t   s1_r, s1_nxt;
  logic            out_valid_r, out_valid_nxt;
  cwc_pkg::out_t   out_r, out_nxt;

  logic            step, makes_result, s1_ready, s2_ready, s1_load;
  logic [9:0]      px;
  logic [10:0]     lb;
  logic [8:0]      lines;
  logic [9:0]      r_inc;
  logic [11:0]     c_inc;
  logic            rows_done, skip_done, line_done, frame_done;
  logic [cwc_pkg::LEN_W-1:0]  len;
  logic [cwc_pkg::LEN_W-1:0]  len_m1;
  logic [cwc_pkg::PROD_W-1:0] prod;
  logic [cwc_pkg::PROD_W-1:0] quot;

  // window limits
  always_comb begin
    if (cfg.line_pixels == '0) begin
      px = 10'd1;
    end else if (12'(cfg.line_pixels) > 12'(cwc_pkg::MAX_LINE_PIXELS)) begin
      px = 10'(cwc_pkg::MAX_LINE_PIXELS);
    end else begin
      px = cfg.line_pixels;
    end
    if (cfg.frame_lines == '0) begin
      lines = 9'd1;
    end else if (12'(cfg.frame_lines) > 12'(cwc_pkg::MAX_FRAME_LINES)) begin
      lines = 9'(cwc_pkg::MAX_FRAME_LINES);
    end else begin
      lines = cfg.frame_lines;
    end
    lb  = cfg.mono_mode ? {1'b0, px} : {px, 1'b0};
    len = cwc_pkg::LEN_W'(lb) * cwc_pkg::LEN_W'(lines);
  end

  assign r_inc      = row_r + 10'd1;
  assign c_inc      = col_r + 12'd1;
  assign rows_done  = r_inc >= cfg.row_skip;
  assign skip_done  = c_inc >= {2'b00, cfg.column_skip};
  assign line_done  = c_inc >= {1'b0, lb};
  assign frame_done = {2'b00, r_inc} >= {3'b000, lines};

  assign s2_ready     = !out_valid_r || !out_stall;
  assign s1_ready     = !s1_valid_r || s2_ready;
  assign makes_result = !q_data.arm && (phase_r == cwc_pkg::PH_GRAB) &&
                        q_data.pc_rise && parity_r;
  assign q_pop        = q_valid && (s1_ready || !makes_result);
  assign step         = q_pop && !q_data.arm;
  assign s1_load      = q_pop && makes_result;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (q_pop && q_data.arm) begin
      phase_nxt = cwc_pkg::PH_VSYNC;
    end else if (step) begin
      case (phase_r)
        cwc_pkg::PH_IDLE: begin
          phase_nxt = cwc_pkg::PH_IDLE;
        end
        cwc_pkg::PH_VSYNC: begin
          if (q_data.vs_rise) begin
            phase_nxt = (cfg.row_skip == '0) ? cwc_pkg::PH_LINE : cwc_pkg::PH_ROWS;
          end
        end
        cwc_pkg::PH_ROWS: begin
          if (q_data.hr_rise && rows_done) begin
            phase_nxt = cwc_pkg::PH_LINE;
          end
        end
        cwc_pkg::PH_LINE: begin
          if (q_data.hr_rise) begin
            phase_nxt = (cfg.column_skip == '0) ? cwc_pkg::PH_GRAB : cwc_pkg::PH_COLS;
          end
        end
        cwc_pkg::PH_COLS: begin
          if (q_data.pc_rise && parity_r && skip_done) begin
            phase_nxt = cwc_pkg::PH_GRAB;
          end
        end
        cwc_pkg::PH_GRAB: begin
          if (q_data.pc_rise && parity_r && line_done) begin
            phase_nxt = frame_done ? cwc_pkg::PH_IDLE : cwc_pkg::PH_LINE;
          end
        end
        default: begin
          phase_nxt = cwc_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // counters and result stage
  always_comb begin
    parity_nxt = parity_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    index_nxt  = index_r;
    s1_nxt             = s1_r;
    s1_nxt.pixel_byte  = q_data.data;
    s1_nxt.byte_index  = index_r;
    s1_nxt.line_end    = 1'b0;
    s1_nxt.frame_end   = 1'b0;
    s1_nxt.frame_bytes = '0;
    s1_nxt.chunk_total = '0;
    if (q_pop && q_data.arm) begin
      parity_nxt = 1'b0;
      row_nxt    = '0;
      col_nxt    = '0;
      index_nxt  = '0;
    end else if (step) begin
      case (phase_r)
        cwc_pkg::PH_VSYNC: begin
          if (q_data.vs_rise) begin
            row_nxt = '0;
          end
        end
        cwc_pkg::PH_ROWS: begin
          if (q_data.hr_rise) begin
            row_nxt = rows_done ? '0 : r_inc;
          end
        end
        cwc_pkg::PH_LINE: begin
          if (q_data.hr_rise) begin
            parity_nxt = 1'b0;
            col_nxt    = '0;
          end
        end
        cwc_pkg::PH_COLS: begin
          if (q_data.pc_rise) begin
            parity_nxt = !parity_r;
            if (parity_r) begin
              col_nxt = skip_done ? '0 : c_inc;
            end
          end
        end
        cwc_pkg::PH_GRAB: begin
          if (q_data.pc_rise) begin
            parity_nxt = !parity_r;
            if (parity_r) begin
              index_nxt = index_r + 20'd1;
              if (line_done) begin
                col_nxt         = '0;
                row_nxt         = r_inc;
                s1_nxt.line_end = 1'b1;
                if (frame_done) begin
                  s1_nxt.frame_end   = 1'b1;
                  s1_nxt.frame_bytes = len;
                end
              end else begin
                col_nxt = c_inc;
              end
            end
          end
        end
        default: begin
          parity_nxt = parity_r;
        end
      endcase
    end
  end

  always_comb begin
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = s2_ready ? s1_valid_r : out_valid_r;
  end

  // chunk count by reciprocal multiply, exact for any frame length
  assign len_m1 = s1_r.frame_bytes - cwc_pkg::LEN_W'(1);
  assign prod   = cwc_pkg::PROD_W'(len_m1) *
                  cwc_pkg::PROD_W'(cwc_pkg::CHUNK_RECIP[cwc_pkg::RECIP_W-1:0]);
  assign quot   = prod >> cwc_pkg::CHUNK_SHIFT;

  always_comb begin
    out_nxt             = s1_r;
    out_nxt.chunk_total = s1_r.frame_end ? 12'(quot + cwc_pkg::PROD_W'(1)) : 12'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cwc_pkg::PH_IDLE;
      parity_r    <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      index_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      parity_r    <= parity_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      index_r     <= index_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sv/camera_window_capture.sv
// Camera window capture, top level: configuration registers, front, queue and back.
// Takes one transaction per cycle while in_stall is low; a result passes through the queue,
// the sequencer register and the chunk-count output register to out_valid, held under out_stall.
// Throughput is one transaction per cycle unless stalled, set by the single-step sequencer in the back.
// Reset (rst_n low, synchronous): registers to 640, 480, 3, 3, RGB565; capture idle,
// pin history and counters cleared, queue and output empty. No clearing pass.

module camera_window_capture (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cwc_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output cwc_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cwc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cwc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  cwc_pkg::cfg_t cfg_r, cfg_nxt;
  cwc_pkg::evt_t push_data, q_data;
  logic          q_full, q_push, q_valid, q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        cwc_pkg::CFG_LINE_PIXELS: cfg_nxt.line_pixels = cfg_data;
        cwc_pkg::CFG_FRAME_LINES: cfg_nxt.frame_lines = cfg_data[8:0];
        cwc_pkg::CFG_COLUMN_SKIP: cfg_nxt.column_skip = cfg_data;
        cwc_pkg::CFG_ROW_SKIP:    cfg_nxt.row_skip    = cfg_data;
        cwc_pkg::CFG_MONO_MODE:   cfg_nxt.mono_mode   = cfg_data[0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_pixels <= 10'd640;
      cfg_r.frame_lines <= 9'd480;
      cfg_r.column_skip <= 10'd3;
      cfg_r.row_skip    <= 10'd3;
      cfg_r.mono_mode   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cwc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  cwc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  cwc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
